>>> rtl/core/pump_duty_controller_assert.svh
// Assertion macros for the pump duty controller checker.
`ifndef PUMP_DUTY_CONTROLLER_ASSERT_SVH
`define PUMP_DUTY_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PDC_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PDC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/core/pdc_pkg.sv
// Types, constants and the duty clamp shared by the pump duty controller.
package pdc_pkg;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_RAMP  = 2'd1,
    OP_ADAPT = 2'd2
  } op_t;

  localparam logic [1:0] CFG_MIN_DUTY       = 2'd0;
  localparam logic [1:0] CFG_MAX_DUTY       = 2'd1;
  localparam logic [1:0] CFG_RATE_TOLERANCE = 2'd2;
  localparam logic [1:0] CFG_ADJUST_STEP    = 2'd3;

  localparam logic [9:0]  FULL_SCALE           = 10'd1023;
  localparam logic [9:0]  RST_MIN_DUTY         = 10'd200;
  localparam logic [9:0]  RST_MAX_DUTY         = 10'd1023;
  localparam logic [14:0] RST_RATE_TOLERANCE   = 15'd128;
  localparam logic [9:0]  RST_ADJUST_STEP      = 10'd50;

  typedef struct packed {
    logic [9:0]  min_duty;
    logic [9:0]  max_duty;
    logic [14:0] rate_tolerance;
    logic [9:0]  adjust_step;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] requested_duty;
    logic [9:0]  ramp_target;
    logic [15:0] measured_rate;
    logic [15:0] wanted_rate;
    logic        bus_powered;
  } item_t;

  typedef struct packed {
    logic [9:0] duty;
    logic       raised;
  } clamp_t;

  // What the held item does this cycle.
  typedef struct packed {
    logic       emit;    // a result is produced
    logic       done;    // item finished once this step goes through
    logic [9:0] duty;
    logic       raised;
    logic       last;
  } step_t;

  // Full-scale clamp, then lift of small nonzero values to the minimum.
  function automatic clamp_t clamp_duty(input logic [15:0] v, input cfg_t cfg);
    logic [15:0] c;
    clamp_t      r;
    c = (v > {6'd0, FULL_SCALE}) ? {6'd0, cfg.max_duty} : v;
    r.raised = 1'b0;
    if ((c != 16'd0) && (c < {6'd0, cfg.min_duty})) begin
      c = {6'd0, cfg.min_duty};
      r.raised = 1'b1;
    end
    r.duty = c[9:0];
    return r;
  endfunction

endpackage

>>> rtl/core/pdc_cfg_regs.sv
// Configuration register file of the pump duty controller.
module pdc_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  output pdc_pkg::cfg_t      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_duty       <= pdc_pkg::RST_MIN_DUTY;
      cfg.max_duty       <= pdc_pkg::RST_MAX_DUTY;
      cfg.rate_tolerance <= pdc_pkg::RST_RATE_TOLERANCE;
      cfg.adjust_step    <= pdc_pkg::RST_ADJUST_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pdc_pkg::CFG_MIN_DUTY:       cfg.min_duty       <= cfg_data[9:0];
        pdc_pkg::CFG_MAX_DUTY:       cfg.max_duty       <= cfg_data[9:0];
        pdc_pkg::CFG_RATE_TOLERANCE: cfg.rate_tolerance <= cfg_data;
        pdc_pkg::CFG_ADJUST_STEP:    cfg.adjust_step    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/pdc_datapath.sv
// Per-cycle result logic: set, ramp step and adapt, each through the clamp.
module pdc_datapath #(
  parameter int RAMP_STEPS = 50
) (
  input  pdc_pkg::item_t                              item,
  input  pdc_pkg::cfg_t                               cfg,
  input  logic [9:0]                                  duty_now,
  input  logic [$clog2(RAMP_STEPS+1)-1:0]             ramp_index,
  input  logic [$clog2(1023*RAMP_STEPS+1)-1:0]        ramp_acc,
  output logic [$clog2(1023*RAMP_STEPS+1)-1:0]        ramp_acc_next,
  output pdc_pkg::step_t                              step
);

  localparam int IDX_W = $clog2(RAMP_STEPS + 1);
  localparam int ACC_W = $clog2(1023 * RAMP_STEPS + 1);
  // Reciprocal scaling: exact floor division for every product span * index.
  localparam int RK = ACC_W + 6;
  localparam logic [RK:0] RECIP = (RK + 1)'(((2 ** RK) + RAMP_STEPS - 1) / RAMP_STEPS);
  localparam int PW = ACC_W + RK + 1;

  logic                ramp_down;
  logic [9:0]          span;
  logic [PW-1:0]       prod;
  logic [9:0]          delta;
  logic [15:0]         ramp_value;
  logic signed [16:0]  err;
  logic [16:0]         mag;
  logic [9:0]          dec;
  logic [15:0]         adapt_value;
  logic                adapt_emit;
  pdc_pkg::clamp_t     clamped;
  logic [15:0]         raw;

  // ramp: delta = floor(span * index / RAMP_STEPS), acc holds span * index
  assign ramp_down     = item.ramp_target < cfg.min_duty;
  assign span          = ramp_down ? (cfg.min_duty - item.ramp_target)
                                   : (item.ramp_target - cfg.min_duty);
  assign ramp_acc_next = ramp_acc + ACC_W'(span);
  assign prod          = PW'(ramp_acc) * PW'(RECIP);
  assign delta         = prod[RK +: 10];
  assign ramp_value    = ramp_down ? (16'(cfg.min_duty) - 16'(delta))
                                   : (16'(cfg.min_duty) + 16'(delta));

  // adapt: error = wanted - measured, exact in 17 bits
  assign err = $signed({item.wanted_rate[15], item.wanted_rate})
             - $signed({item.measured_rate[15], item.measured_rate});
  assign mag = err[16] ? 17'(-err) : 17'(err);
  assign dec = {1'b0, cfg.adjust_step[9:1]};
  assign adapt_emit = item.bus_powered && !(mag < {2'b00, cfg.rate_tolerance});
  always_comb begin
    if (!err[16] && (err != 17'sd0)) begin
      adapt_value = 16'(duty_now) + 16'(cfg.adjust_step);
    end else if (duty_now > dec) begin
      adapt_value = 16'(duty_now - dec);
    end else begin
      adapt_value = 16'd0;
    end
  end

  always_comb begin
    step.emit = 1'b0;
    step.done = 1'b1;
    step.last = 1'b1;
    raw       = item.requested_duty;
    unique case (item.operation)
      pdc_pkg::OP_SET: begin
        step.emit = 1'b1;
      end
      pdc_pkg::OP_RAMP: begin
        step.emit = 1'b1;
        step.done = (ramp_index == IDX_W'(RAMP_STEPS));
        step.last = step.done;
        raw       = ramp_value;
      end
      pdc_pkg::OP_ADAPT: begin
        step.emit = adapt_emit;
        raw       = adapt_value;
      end
      default: ;  // unused code: no result, nothing changes
    endcase
    clamped     = pdc_pkg::clamp_duty(raw, cfg);
    step.duty   = clamped.duty;
    step.raised = clamped.raised;
  end

endmodule

>>> rtl/core/pump_duty_controller.sv
// Pump duty controller top level: input register, ramp sequencer, result register.
//
// Usage: an item transferred on the input channel sits in the input register
// for as long as it has results to give. Set and adapt give at most one
// result, so a new item can be transferred every cycle while the output does
// not stall. A ramp gives RAMP_STEPS+1 results, one per cycle while the output
// does not stall, from a sequencer that keeps the step index and the running
// product span*index; in_stall is high until its final step (marked by last)
// has gone into the result register. Adapt in the dead band, adapt with the
// bus unpowered and the unused operation code give no result and free the
// input register without waiting on the output. A result is formed from the
// item in the input register and is held in the result register until the
// output transfer, while the next item may already be taken. in_stall follows
// out_stall combinationally when both registers are full. The driven duty
// (duty_now) is updated when a result is formed, so an adapt right behind
// another item sees its outcome. The configuration port is always ready;
// write it only while the block is idle.
module pump_duty_controller #(
  parameter int RAMP_STEPS = 50
) (
  input  logic               clk,
  input  logic               rst,
  // item input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [15:0]        requested_duty,
  input  logic [9:0]         ramp_target,
  input  logic signed [15:0] measured_rate,
  input  logic signed [15:0] wanted_rate,
  input  logic               bus_powered,
  // result output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         duty,
  output logic               raised_to_min,
  output logic               last,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  localparam int IDX_W = $clog2(RAMP_STEPS + 1);
  localparam int ACC_W = $clog2(1023 * RAMP_STEPS + 1);

  pdc_pkg::cfg_t    cfg;
  pdc_pkg::item_t   item;          // input register payload
  logic             item_valid;
  logic [9:0]       duty_now;      // last duty driven
  logic [IDX_W-1:0] ramp_index;
  logic [ACC_W-1:0] ramp_acc;
  logic [ACC_W-1:0] ramp_acc_next;
  pdc_pkg::step_t   step;

  logic out_free;   // result register can take a value this cycle
  logic fire;       // held item takes its step this cycle
  logic release_item;
  logic accept;

  pdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdc_datapath #(
    .RAMP_STEPS (RAMP_STEPS)
  ) u_dp (
    .item          (item),
    .cfg           (cfg),
    .duty_now      (duty_now),
    .ramp_index    (ramp_index),
    .ramp_acc      (ramp_acc),
    .ramp_acc_next (ramp_acc_next),
    .step          (step)
  );

  // A step with no result needs no room downstream.
  assign out_free     = !out_valid || !out_stall;
  assign fire         = item_valid && (!step.emit || out_free);
  assign release_item = fire && step.done;
  assign in_stall     = item_valid && !release_item;
  assign accept       = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (release_item) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.operation      <= operation;
      item.requested_duty <= requested_duty;
      item.ramp_target    <= ramp_target;
      item.measured_rate  <= measured_rate;
      item.wanted_rate    <= wanted_rate;
      item.bus_powered    <= bus_powered;
    end
  end

  // ramp sequencer: back to zero once the final step is out
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_index <= '0;
      ramp_acc   <= '0;
    end else if (fire && (item.operation == pdc_pkg::OP_RAMP)) begin
      if (step.done) begin
        ramp_index <= '0;
        ramp_acc   <= '0;
      end else begin
        ramp_index <= ramp_index + IDX_W'(1);
        ramp_acc   <= ramp_acc_next;
      end
    end
  end

  // driven duty
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_now <= '0;
    end else if (fire && step.emit) begin
      duty_now <= step.duty;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && step.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step.emit) begin
      duty          <= step.duty;
      raised_to_min <= step.raised;
      last          <= step.last;
    end
  end

endmodule

>>> rtl/core/pdc_checker.sv
// Port-level checker for the pump duty controller, bound to the top level.
`include "pump_duty_controller_assert.svh"

module pdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  duty,
  input logic        raised_to_min,
  input logic        last
);

  // a result waiting on a stall keeps its value
  `PDC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(duty) && $stable(raised_to_min) && $stable(last), "stalled result changed")

  // a lifted duty is never the pump-off value
  `PDC_ASSERT_NOW(a_raised_nonzero, clk, rst, out_valid && raised_to_min, duty != 10'd0, "raised result with zero duty")

  // inside a ramp the next step is ready right after each transfer
  `PDC_ASSERT_NEXT(a_ramp_gapless, clk, rst, out_valid && !out_stall && !last, out_valid, "gap inside a ramp")

  // both registers are empty straight after reset
  `PDC_ASSERT_NOW(a_reset_idle, clk, rst, $past(rst), !out_valid && !in_stall, "not idle after reset")

endmodule

bind pump_duty_controller pdc_checker u_pdc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .duty          (duty),
  .raised_to_min (raised_to_min),
  .last          (last)
);

>>> tb/sv/pump_duty_controller_tb.sv
// Self-checking testbench for the pump duty controller: directed table, then random phases.
module pump_duty_controller_tb;

  localparam int RAMP_LEN       = 50;     // ramp gives RAMP_LEN+1 duties
  localparam int WATCHDOG_LIMIT = 1000;   // cycles with no transfer at all
  localparam int SETTLE_CYCLES  = 8;      // input reg + result reg, with margin
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASE_ITEMS    = 46;
  localparam int BY_PREDICTOR   = -1;     // table row checked against the predictor
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Handy Q8.8 rate values
  localparam logic [15:0] RATE_MAX  = 16'h7FFF;
  localparam logic [15:0] RATE_MIN  = 16'h8000;
  localparam logic [15:0] RATE_ZERO = 16'h0000;

  typedef struct packed {
    logic [9:0] duty;
    logic       raised;
    logic       last;
  } duty_result_t;

  typedef struct {
    pdc_pkg::item_t it;
    int             fixed_n;       // 0 or 1 typed-in results, or BY_PREDICTOR
    logic [9:0]     fixed_duty;
    logic           fixed_raised;
  } table_row_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  initial begin
    forever #6 clk = ~clk;
  end

  // DUT ports; every input is known from time zero
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [1:0]  operation      = pdc_pkg::OP_SET;
  logic [15:0] requested_duty = '0;
  logic [9:0]  ramp_target    = '0;
  logic [15:0] measured_rate  = '0;
  logic [15:0] wanted_rate    = '0;
  logic        bus_powered    = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [9:0]  duty;
  logic        raised_to_min;
  logic        last;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index      = pdc_pkg::CFG_MIN_DUTY;
  logic [14:0] cfg_data       = '0;

  pump_duty_controller #(
    .RAMP_STEPS(RAMP_LEN)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .requested_duty (requested_duty),
    .ramp_target    (ramp_target),
    .measured_rate  (measured_rate),
    .wanted_rate    (wanted_rate),
    .bus_powered    (bus_powered),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .duty           (duty),
    .raised_to_min  (raised_to_min),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Duty predictor: own copy of the registers and of the driven duty.
  // ---------------------------------------------------------------------------
  logic [9:0]  pred_min_duty;
  logic [9:0]  pred_max_duty;
  logic [14:0] pred_tolerance;
  logic [9:0]  pred_step;
  logic [9:0]  pred_duty_now;

  duty_result_t forecast_buf [0:RAMP_LEN];
  duty_result_t expected_duties [$];   // oldest first
  duty_result_t oldest;

  int  error_count = 0;
  bit  idle_on     = 1'b1;             // random gaps and stalls allowed
  int  stall_left  = 0;
  int  quiet_cycles = 0;

  task automatic predictor_reset();
    pred_min_duty  = pdc_pkg::RST_MIN_DUTY;
    pred_max_duty  = pdc_pkg::RST_MAX_DUTY;
    pred_tolerance = pdc_pkg::RST_RATE_TOLERANCE;
    pred_step      = pdc_pkg::RST_ADJUST_STEP;
    pred_duty_now  = '0;
  endtask

  task automatic note_register(input logic [1:0] idx, input logic [14:0] v);
    case (idx)
      pdc_pkg::CFG_MIN_DUTY:       pred_min_duty  = v[9:0];
      pdc_pkg::CFG_MAX_DUTY:       pred_max_duty  = v[9:0];
      pdc_pkg::CFG_RATE_TOLERANCE: pred_tolerance = v;
      pdc_pkg::CFG_ADJUST_STEP:    pred_step      = v[9:0];
      default: ;
    endcase
  endtask

  // Full-scale clamp, then lift to the minimum; updates the driven duty.
  function automatic duty_result_t drive_duty(input int unsigned v, input bit fin);
    duty_result_t r;
    r.raised = 1'b0;
    if (v > int'(pdc_pkg::FULL_SCALE)) v = pred_max_duty;
    if (v != 0 && v < pred_min_duty) begin
      v = pred_min_duty;
      r.raised = 1'b1;
    end
    r.duty = 10'(v);
    r.last = fin;
    pred_duty_now = r.duty;
    return r;
  endfunction

  // Fills forecast_buf with the duties one item gives; returns how many.
  function automatic int forecast(input pdc_pkg::item_t it);
    int unsigned start, span, delta, v, dec, mag;
    int          err, k;
    bit          down;
    forecast = 0;
    if (it.operation == pdc_pkg::OP_SET) begin
      forecast_buf[0] = drive_duty(it.requested_duty, 1'b1);
      forecast = 1;
    end else if (it.operation == pdc_pkg::OP_RAMP) begin
      start = pred_min_duty;
      down  = it.ramp_target < start;
      span  = down ? start - it.ramp_target : it.ramp_target - start;
      for (k = 0; k <= RAMP_LEN; k++) begin
        delta = (span * k) / RAMP_LEN;
        v     = down ? start - delta : start + delta;
        forecast_buf[k] = drive_duty(v, k == RAMP_LEN);
      end
      forecast = RAMP_LEN + 1;
    end else if (it.operation == pdc_pkg::OP_ADAPT) begin
      err = int'($signed(it.wanted_rate)) - int'($signed(it.measured_rate));
      mag = (err < 0) ? -err : err;
      // dead band and unpowered bus give nothing
      if (mag >= pred_tolerance && it.bus_powered) begin
        if (err > 0) begin
          v = pred_duty_now + pred_step;
        end else begin
          dec = pred_step / 2;
          v   = (pred_duty_now > dec) ? pred_duty_now - dec : 0;
        end
        forecast_buf[0] = drive_duty(v, 1'b1);
        forecast = 1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts while idle_on is set.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_duties.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual duty=%0d raised=%0b last=%0b",
                 $time, duty, raised_to_min, last);
      end else begin
        oldest = expected_duties.pop_front();
        if (oldest.duty !== duty || oldest.raised !== raised_to_min
            || oldest.last !== last) begin
          error_count++;
          $display({"%0t: result mismatch: expected duty=%0d raised=%0b last=%0b,",
                    " actual duty=%0d raised=%0b last=%0b"},
                   $time, oldest.duty, oldest.raised, oldest.last, duty, raised_to_min, last);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Presents one item, optionally after a gap, and returns at its transfer edge.
  // in_valid is left high so a following item keeps it up without a dip.
  task automatic send_item(input pdc_pkg::item_t it);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation      <= it.operation;
    requested_duty <= it.requested_duty;
    ramp_target    <= it.ramp_target;
    measured_rate  <= it.measured_rate;
    wanted_rate    <= it.wanted_rate;
    bus_powered    <= it.bus_powered;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Block idle: no item offered, all results in, and items that give nothing
  // have had time to leave the input register.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back; junk in the unused data bits of
  // the 10-bit registers must be ignored.
  task automatic apply_setting(input logic [9:0] mn, input logic [9:0] mx,
                               input logic [14:0] tol, input logic [9:0] stp);
    logic [1:0]  regs [4];
    logic [14:0] vals [4];
    int          k;
    regs[0] = pdc_pkg::CFG_MIN_DUTY;       vals[0] = {5'($urandom), mn};
    regs[1] = pdc_pkg::CFG_MAX_DUTY;       vals[1] = {5'($urandom), mx};
    regs[2] = pdc_pkg::CFG_RATE_TOLERANCE; vals[2] = tol;
    regs[3] = pdc_pkg::CFG_ADJUST_STEP;    vals[3] = {5'($urandom), stp};
    wait_for_idle();
    for (k = 0; k < 4; k++) begin
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      note_register(regs[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random item; about half the adapts land near the tolerance edge.
  function automatic pdc_pkg::item_t random_item();
    pdc_pkg::item_t it;
    int             pick, band, offs;
    pick = $urandom_range(0, 19);
    if (pick < 6)       it.operation = pdc_pkg::OP_SET;
    else if (pick < 10) it.operation = pdc_pkg::OP_RAMP;
    else if (pick < 19) it.operation = pdc_pkg::OP_ADAPT;
    else                it.operation = OP_UNUSED;
    case ($urandom_range(0, 2))
      0:       it.requested_duty = 16'($urandom);
      1:       it.requested_duty = 16'($urandom_range(0, 1100));
      default: it.requested_duty = 16'($urandom_range(0, 260));
    endcase
    it.ramp_target   = 10'($urandom);
    it.measured_rate = 16'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      band = int'(pred_tolerance) + 2;
      offs = int'($urandom_range(0, 2 * band)) - band;
      it.wanted_rate = 16'(int'($signed(it.measured_rate)) + offs);
    end else begin
      it.wanted_rate = 16'($urandom);
    end
    it.bus_powered = ($urandom_range(0, 7) != 0);
    return it;
  endfunction

  function automatic table_row_t row(input logic [1:0] op, input logic [15:0] req,
                                     input logic [9:0] tgt, input logic [15:0] meas,
                                     input logic [15:0] want, input logic bus,
                                     input int n, input logic [9:0] d, input logic r);
    table_row_t t;
    t.it.operation      = op;
    t.it.requested_duty = req;
    t.it.ramp_target    = tgt;
    t.it.measured_rate  = meas;
    t.it.wanted_rate    = want;
    t.it.bus_powered    = bus;
    t.fixed_n           = n;
    t.fixed_duty        = d;
    t.fixed_raised      = r;
    return t;
  endfunction

  table_row_t directed_rows [$];

  initial begin
    table_row_t     t;
    pdc_pkg::item_t it;
    duty_result_t   typed;
    int             i, k, n, ph;

    predictor_reset();

    // Reset register values: min 200, max 1023, tolerance 128, step 50; duty starts at 0.
    // Set at the extremes and around the minimum
    directed_rows.push_back(row(pdc_pkg::OP_SET, 16'd0, 10'd0, RATE_ZERO, RATE_ZERO, 1'b0,
                                1, 10'd0, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_SET, 16'hFFFF, 10'd0, RATE_ZERO, RATE_ZERO, 1'b1,
                                1, 10'd1023, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_SET, 16'd1024, 10'd0, RATE_ZERO, RATE_ZERO, 1'b0,
                                1, 10'd1023, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_SET, 16'd1023, 10'd0, RATE_ZERO, RATE_ZERO, 1'b0,
                                1, 10'd1023, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_SET, 16'd1, 10'd0, RATE_ZERO, RATE_ZERO, 1'b0,
                                1, 10'd200, 1'b1));
    directed_rows.push_back(row(pdc_pkg::OP_SET, 16'd199, 10'd0, RATE_ZERO, RATE_ZERO, 1'b0,
                                1, 10'd200, 1'b1));
    directed_rows.push_back(row(pdc_pkg::OP_SET, 16'd200, 10'd0, RATE_ZERO, RATE_ZERO, 1'b0,
                                1, 10'd200, 1'b0));
    // Unused code: nothing out, nothing changed
    directed_rows.push_back(row(OP_UNUSED, 16'hFFFF, 10'h3FF, RATE_MIN, RATE_MAX, 1'b1,
                                0, 10'd0, 1'b0));
    // Adapt: unpowered bus, dead band both signs, then exactly on the band edge
    directed_rows.push_back(row(pdc_pkg::OP_ADAPT, 16'd0, 10'd0, RATE_MIN, RATE_MAX, 1'b0,
                                0, 10'd0, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_ADAPT, 16'd0, 10'd0, RATE_ZERO, 16'd100, 1'b1,
                                0, 10'd0, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_ADAPT, 16'd0, 10'd0, 16'd127, RATE_ZERO, 1'b1,
                                0, 10'd0, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_ADAPT, 16'd0, 10'd0, RATE_ZERO, 16'd128, 1'b1,
                                BY_PREDICTOR, 10'd0, 1'b0));
    // Largest negative and positive error
    directed_rows.push_back(row(pdc_pkg::OP_ADAPT, 16'd0, 10'd0, RATE_MAX, RATE_MIN, 1'b1,
                                BY_PREDICTOR, 10'd0, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_ADAPT, 16'd0, 10'd0, RATE_MIN, RATE_MAX, 1'b1,
                                BY_PREDICTOR, 10'd0, 1'b0));
    // Ramps: up to full scale, down to zero, down to a lifted end, flat
    directed_rows.push_back(row(pdc_pkg::OP_RAMP, 16'd0, 10'd1023, RATE_ZERO, RATE_ZERO, 1'b0,
                                BY_PREDICTOR, 10'd0, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_RAMP, 16'd0, 10'd0, RATE_ZERO, RATE_ZERO, 1'b0,
                                BY_PREDICTOR, 10'd0, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_RAMP, 16'd0, 10'd50, RATE_ZERO, RATE_ZERO, 1'b0,
                                BY_PREDICTOR, 10'd0, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_RAMP, 16'd0, 10'd200, RATE_ZERO, RATE_ZERO, 1'b0,
                                BY_PREDICTOR, 10'd0, 1'b0));
    // Increase past full scale goes to max_duty
    directed_rows.push_back(row(pdc_pkg::OP_SET, 16'd1000, 10'd0, RATE_ZERO, RATE_ZERO, 1'b0,
                                1, 10'd1000, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_ADAPT, 16'd0, 10'd0, RATE_MIN, RATE_MAX, 1'b1,
                                BY_PREDICTOR, 10'd0, 1'b0));
    // Decrease from zero stays at zero, unlifted
    directed_rows.push_back(row(pdc_pkg::OP_SET, 16'd0, 10'd0, RATE_ZERO, RATE_ZERO, 1'b0,
                                1, 10'd0, 1'b0));
    directed_rows.push_back(row(pdc_pkg::OP_ADAPT, 16'd0, 10'd0, RATE_ZERO, RATE_MIN, 1'b1,
                                BY_PREDICTOR, 10'd0, 1'b0));
    // Decrease below the minimum is lifted back
    directed_rows.push_back(row(pdc_pkg::OP_SET, 16'd10, 10'd0, RATE_ZERO, RATE_ZERO, 1'b0,
                                1, 10'd200, 1'b1));
    directed_rows.push_back(row(pdc_pkg::OP_ADAPT, 16'd0, 10'd0, RATE_ZERO, RATE_MIN, 1'b1,
                                BY_PREDICTOR, 10'd0, 1'b0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, reset configuration
    for (i = 0; i < directed_rows.size(); i++) begin
      t = directed_rows[i];
      send_item(t.it);
      n = forecast(t.it);        // keeps the predictor's duty in step
      if (t.fixed_n == BY_PREDICTOR) begin
        for (k = 0; k < n; k++) expected_duties.push_back(forecast_buf[k]);
      end else if (t.fixed_n == 1) begin
        typed.duty   = t.fixed_duty;
        typed.raised = t.fixed_raised;
        typed.last   = 1'b1;
        expected_duties.push_back(typed);
      end
    end

    // Random phases; each one reconfigures the idle block first.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin  // extremes: no floor, no dead band, biggest step
          apply_setting(10'd0, 10'd1023, 15'd0, 10'd1023);
          idle_on = 1'b1;
        end
        1: begin  // inverted limits, widest band, zero step
          apply_setting(10'd1023, 10'd0, 15'h7FFF, 10'd0);
          idle_on = 1'b1;
        end
        2: begin  // inverted nonzero limits, a stretch without idling
          apply_setting(10'd600, 10'd300, 15'($urandom_range(0, 300)), 10'($urandom));
          idle_on = 1'b0;
        end
        3: begin
          apply_setting(10'($urandom_range(0, 400)), 10'($urandom_range(600, 1023)),
                        15'($urandom_range(0, 512)), 10'($urandom));
          idle_on = 1'b1;
        end
        4: begin  // back to the reset values
          apply_setting(pdc_pkg::RST_MIN_DUTY, pdc_pkg::RST_MAX_DUTY,
                        pdc_pkg::RST_RATE_TOLERANCE, pdc_pkg::RST_ADJUST_STEP);
          idle_on = 1'b1;
        end
        default: begin  // last part: anything goes, no idling
          apply_setting(10'($urandom), 10'($urandom), 15'($urandom), 10'($urandom));
          idle_on = 1'b0;
        end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        it = random_item();
        send_item(it);
        n = forecast(it);
        for (k = 0; k < n; k++) expected_duties.push_back(forecast_buf[k]);
      end
    end

    // Drain and make sure nothing else comes out.
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_duties.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
